@@ rtl/core/coprocessor_timer_interrupt_unit_macros.svh @@
// Assertion macros for the coprocessor timer and interrupt unit
`ifndef COPROCESSOR_TIMER_INTERRUPT_UNIT_MACROS_SVH
`define COPROCESSOR_TIMER_INTERRUPT_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define CTI_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cti assertion failed");
`define CTI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cti assertion failed");
`else
`define CTI_ASSERT_IMP(label, ante, cons)
`define CTI_ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ rtl/core/cti_pkg.sv @@
// Types, constants and codes shared by the timer and interrupt unit
package cti_pkg;

    localparam int DOT_CYCLES    = 4;
    localparam int LINEAR_H_WRAP = 2048;
    localparam int LINEAR_V_WRAP = 512;

    localparam int H_CNT_W  = 12;
    localparam int V_CNT_W  = 9;
    localparam int DELTA_W  = 8;
    localparam int H_SUM_W  = 13;
    localparam int H_PREV_W = H_SUM_W + 1;
    localparam int V_WRAP_W = 11;

    localparam logic [H_SUM_W-1:0]  H_WRAP_LIN = H_SUM_W'(LINEAR_H_WRAP);
    localparam logic [V_WRAP_W-1:0] V_WRAP_LIN = V_WRAP_W'(LINEAR_V_WRAP);
    localparam logic [H_SUM_W-1:0]  DOT_SCALE  = H_SUM_W'(DOT_CYCLES);
    localparam logic [DELTA_W-1:0]  HALT_DELTA = DELTA_W'(6);

    localparam int BIT_NMI   = 0;
    localparam int BIT_DMA   = 1;
    localparam int BIT_TIMER = 2;
    localparam int BIT_HOST  = 3;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 32;

    localparam logic [10:0] H_LINE_RST = 11'd1364;
    localparam logic [8:0]  V_LINE_RST = 9'd262;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LINEAR_MODE    = 3'd0,
        REG_TIMER_IRQ_MODE = 3'd1,
        REG_H_IRQ_POSITION = 3'd2,
        REG_V_IRQ_POSITION = 3'd3,
        REG_IRQ_ENABLE     = 3'd4,
        REG_H_LINE_LENGTH  = 3'd5,
        REG_V_LINE_COUNT   = 3'd6
    } reg_index_t;

    typedef enum logic [1:0] {
        VEC_NONE = 2'd0,
        VEC_NMI  = 2'd1,
        VEC_IRQ  = 2'd2
    } vector_t;

    typedef enum logic [1:0] {
        SRC_NONE  = 2'd0,
        SRC_TIMER = 2'd1,
        SRC_DMA   = 2'd2,
        SRC_HOST  = 2'd3
    } irq_src_t;

    typedef struct packed {
        logic        linear_mode;
        logic [1:0]  timer_irq_mode;
        logic [8:0]  h_irq_position;
        logic [8:0]  v_irq_position;
        logic [1:0]  irq_enable;
        logic [10:0] h_line_length;
        logic [8:0]  v_line_count;
    } cfg_t;

    // fields listed high to low so that the last field sits in the lowest bits
    typedef struct packed {
        logic [3:0]         status_clear_mask;
        logic [3:0]         rearm_mask;
        logic               irq_masked;
        logic               host_irq_request;
        logic               nmi_request;
        logic               halted;
        logic [DELTA_W-1:0] elapsed_cycles;
    } in_item_t;

    typedef struct packed {
        logic        timer_edge;
        logic [8:0]  v_count;
        logic [10:0] h_count;
        logic [3:0]  status_flags;
        logic        wake_cpu;
        irq_src_t    irq_source;
        vector_t     vector_taken;
    } out_item_t;

    typedef struct packed {
        logic [H_CNT_W-1:0] h_counter;
        logic [V_CNT_W-1:0] v_counter;
        logic               timer_level_last;
        logic [3:0]         serviced_latch;
        logic [3:0]         status_bits;
    } state_t;

    localparam int IN_W  = $bits(in_item_t);
    localparam int OUT_W = $bits(out_item_t);

endpackage

@@ rtl/core/coprocessor_timer_interrupt_unit.sv @@
// Top level of the coprocessor timer and interrupt unit
// One result per accepted slot. A slot is registered at acceptance, evaluated against the
// beam counter and interrupt latches in the following cycle, and its result then passes
// through the output register to the master side. A new slot is taken every cycle while
// results are drained; the counter and latch update between input register and output
// register sets that rate. Configuration writes take effect the cycle after the
// transaction and are always accepted.
module coprocessor_timer_interrupt_unit
(
    input  logic                              clk,
    input  logic                              rst_n,
    // [7:0] elapsed_cycles, [8] halted, [9] nmi_request, [10] host_irq_request,
    // [11] irq_masked, [15:12] rearm_mask, [19:16] status_clear_mask
    input  logic [cti_pkg::IN_TDATA_W-1:0]    s_tdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [1:0] vector_taken, [3:2] irq_source, [4] wake_cpu, [8:5] status_flags,
    // [19:9] h_count, [28:20] v_count, [29] timer_edge
    output logic [cti_pkg::OUT_TDATA_W-1:0]   m_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [cti_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cti_pkg::CFG_DATA_W-1:0]    cfg_data
);

`include "coprocessor_timer_interrupt_unit_macros.svh"

    cti_pkg::cfg_t      cfg;
    cti_pkg::in_item_t  in_item_reg;
    logic               in_valid_reg;
    logic               in_valid_next;
    cti_pkg::out_item_t out_item_reg;
    cti_pkg::out_item_t out_item_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    cti_pkg::state_t    state_reg;
    cti_pkg::state_t    state_next;
    logic               s_fire;
    logic               load_out;

    assign cfg_ready = 1'b1;

    cti_cfg_regs u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    cti_step u_step
    (
        .cfg        (cfg),
        .state      (state_reg),
        .item       (in_item_reg),
        .state_next (state_next),
        .result     (out_item_next)
    );

    assign load_out = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || load_out;
    assign s_fire   = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next  = s_fire || (in_valid_reg && !load_out);
        out_valid_next = load_out || (out_valid_reg && !m_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (load_out)
                state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
            in_item_reg <= s_tdata[cti_pkg::IN_W-1:0];
        if (load_out)
            out_item_reg <= out_item_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(cti_pkg::OUT_TDATA_W - cti_pkg::OUT_W)'(0), out_item_reg};

    `CTI_ASSERT_IMP(a_ready_when_empty, !m_tvalid, s_tready)
    `CTI_ASSERT_NEXT(a_load_shows_result, load_out, m_tvalid)
    `CTI_ASSERT_IMP(a_nmi_has_no_source,
        m_tvalid && (out_item_reg.vector_taken == cti_pkg::VEC_NMI),
        out_item_reg.irq_source == cti_pkg::SRC_NONE)
    `CTI_ASSERT_IMP(a_taken_sets_status,
        m_tvalid && (out_item_reg.irq_source == cti_pkg::SRC_HOST),
        out_item_reg.status_flags[cti_pkg::BIT_HOST])

endmodule

@@ rtl/core/cti_cfg_regs.sv @@
// Configuration register file of the timer and interrupt unit
module cti_cfg_regs
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic [cti_pkg::CFG_IDX_W-1:0]   wr_index,
    input  logic [cti_pkg::CFG_DATA_W-1:0]  wr_data,
    output cti_pkg::cfg_t                   cfg
);

    cti_pkg::cfg_t cfg_reg;
    cti_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (cti_pkg::reg_index_t'(wr_index))
                cti_pkg::REG_LINEAR_MODE:    cfg_next.linear_mode    = wr_data[0];
                cti_pkg::REG_TIMER_IRQ_MODE: cfg_next.timer_irq_mode = wr_data[1:0];
                cti_pkg::REG_H_IRQ_POSITION: cfg_next.h_irq_position = wr_data[8:0];
                cti_pkg::REG_V_IRQ_POSITION: cfg_next.v_irq_position = wr_data[8:0];
                cti_pkg::REG_IRQ_ENABLE:     cfg_next.irq_enable     = wr_data[1:0];
                cti_pkg::REG_H_LINE_LENGTH:  cfg_next.h_line_length  = wr_data[10:0];
                cti_pkg::REG_V_LINE_COUNT:   cfg_next.v_line_count   = wr_data[8:0];
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.linear_mode    <= 1'b0;
            cfg_reg.timer_irq_mode <= 2'd0;
            cfg_reg.h_irq_position <= 9'd0;
            cfg_reg.v_irq_position <= 9'd0;
            cfg_reg.irq_enable     <= 2'd0;
            cfg_reg.h_line_length  <= cti_pkg::H_LINE_RST;
            cfg_reg.v_line_count   <= cti_pkg::V_LINE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/core/cti_step.sv @@
// One scheduling slot: interrupt selection, beam counter update, timer edge
module cti_step
(
    input  cti_pkg::cfg_t     cfg,
    input  cti_pkg::state_t   state,
    input  cti_pkg::in_item_t item,
    output cti_pkg::state_t   state_next,
    output cti_pkg::out_item_t result
);

    logic [3:0]                       latch;
    logic [3:0]                       status;
    cti_pkg::vector_t                 vec;
    cti_pkg::irq_src_t                src;
    logic [cti_pkg::DELTA_W-1:0]      delta;
    logic [cti_pkg::H_SUM_W-1:0]      hwrap;
    logic [cti_pkg::V_WRAP_W-1:0]     vwrap;
    logic [cti_pkg::H_SUM_W-1:0]      hsum;
    logic [cti_pkg::H_SUM_W-1:0]      hnew;
    logic signed [cti_pkg::H_PREV_W-1:0] hprev;
    logic [cti_pkg::V_WRAP_W-1:0]     vinc;
    logic [cti_pkg::V_CNT_W-1:0]      vnew;
    logic [cti_pkg::H_SUM_W-1:0]      hpos;
    logic                             wrap;
    logic                             level;
    logic                             edge_hit;

    always_comb
    begin
        latch  = state.serviced_latch & ~item.rearm_mask;
        status = state.status_bits & ~item.status_clear_mask;
        vec    = cti_pkg::VEC_NONE;
        src    = cti_pkg::SRC_NONE;

        if (!item.halted)
        begin
            priority if (item.nmi_request && !latch[cti_pkg::BIT_NMI])
            begin
                latch[cti_pkg::BIT_NMI]  = 1'b1;
                status[cti_pkg::BIT_NMI] = 1'b1;
                vec = cti_pkg::VEC_NMI;
            end
            else if (item.irq_masked)
            begin
                vec = cti_pkg::VEC_NONE;
            end
            else if (cfg.irq_enable[0] && !latch[cti_pkg::BIT_TIMER])
            begin
                latch[cti_pkg::BIT_TIMER]  = 1'b1;
                status[cti_pkg::BIT_TIMER] = 1'b1;
                vec = cti_pkg::VEC_IRQ;
                src = cti_pkg::SRC_TIMER;
            end
            else if (cfg.irq_enable[1] && !latch[cti_pkg::BIT_DMA])
            begin
                latch[cti_pkg::BIT_DMA]  = 1'b1;
                status[cti_pkg::BIT_DMA] = 1'b1;
                vec = cti_pkg::VEC_IRQ;
                src = cti_pkg::SRC_DMA;
            end
            else if (item.host_irq_request && !latch[cti_pkg::BIT_HOST])
            begin
                latch[cti_pkg::BIT_HOST]  = 1'b1;
                status[cti_pkg::BIT_HOST] = 1'b1;
                vec = cti_pkg::VEC_IRQ;
                src = cti_pkg::SRC_HOST;
            end
            else
            begin
                vec = cti_pkg::VEC_NONE;
            end
        end

        delta = item.halted ? cti_pkg::HALT_DELTA : item.elapsed_cycles;
        hwrap = cfg.linear_mode ? cti_pkg::H_WRAP_LIN
                                : cti_pkg::H_SUM_W'(cfg.h_line_length);
        vwrap = cfg.linear_mode ? cti_pkg::V_WRAP_LIN
                                : cti_pkg::V_WRAP_W'(cfg.v_line_count);

        hsum = cti_pkg::H_SUM_W'(state.h_counter) + cti_pkg::H_SUM_W'(delta);
        wrap = (hsum >= hwrap);
        // one subtraction per slot at most
        hnew  = wrap ? (hsum - hwrap) : hsum;
        hprev = $signed(cti_pkg::H_PREV_W'(state.h_counter))
              - (wrap ? $signed(cti_pkg::H_PREV_W'(hwrap)) : '0);

        vinc = cti_pkg::V_WRAP_W'(state.v_counter) + cti_pkg::V_WRAP_W'(1);
        if (!wrap)
            vnew = state.v_counter;
        else if (vinc >= vwrap)
            vnew = '0;
        else
            vnew = vinc[cti_pkg::V_CNT_W-1:0];

        hpos  = cti_pkg::H_SUM_W'(cfg.h_irq_position) * cti_pkg::DOT_SCALE;
        level = (cfg.timer_irq_mode != 2'd0);
        if (cfg.timer_irq_mode[0] &&
            ((hprev >= $signed(cti_pkg::H_PREV_W'(hpos))) || (hnew < hpos)))
            level = 1'b0;
        if (cfg.timer_irq_mode[1] && (vnew != cfg.v_irq_position))
            level = 1'b0;

        edge_hit = !state.timer_level_last && level;
        if (edge_hit)
        begin
            status[cti_pkg::BIT_TIMER] = 1'b1;
            if (cfg.irq_enable[0])
                latch[cti_pkg::BIT_TIMER] = 1'b0;
        end

        state_next.h_counter        = hnew[cti_pkg::H_CNT_W-1:0];
        state_next.v_counter        = vnew;
        state_next.timer_level_last = level;
        state_next.serviced_latch   = latch;
        state_next.status_bits      = status;

        result.vector_taken = vec;
        result.irq_source   = src;
        result.wake_cpu     = (vec != cti_pkg::VEC_NONE);
        result.status_flags = status;
        result.h_count      = hnew[10:0];
        result.v_count      = vnew;
        result.timer_edge   = edge_hit;
    end

endmodule
